FILE: design/segmented_prime_sieve_counter_defines.svh
// ----------------------------------------------------------------------------
// segmented prime sieve counter assertion macros
// shared concurrent assertion forms used by the design files
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_PRIME_SIEVE_COUNTER_DEFINES_SVH
`define SEGMENTED_PRIME_SIEVE_COUNTER_DEFINES_SVH

// implication or plain property checked on every clock edge outside reset
`define SPSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never hold
`define SPSC_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `SPSC_ASSERT(label, clk, rst, !(cond), msg)

`endif

FILE: design/spsc_pkg.sv
// ----------------------------------------------------------------------------
// spsc_pkg
// state type for the sieve controller; command and status types shared by the controller and datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spsc_pkg;

   localparam int COUNT_WIDTH = 11;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_P_CHECK,
      ST_REM_WAIT,
      ST_OFF_CHECK,
      ST_D_CHECK,
      ST_D_WAIT,
      ST_STRIKE,
      ST_P_NEXT,
      ST_COUNT,
      ST_COUNT_LAST,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic init_step;
      logic p_init;
      logic sel_d;
      logic div_lo;
      logic div_p;
      logic off_calc;
      logic d_init;
      logic d_next;
      logic strike;
      logic p_next;
      logic cnt_start;
      logic cnt_step;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic load_err;
      logic init_last;
      logic sq_ok;
      logic div_busy;
      logic rem_zero;
      logic off_lt_span;
      logic cnt_more;
      logic out_free;
   } status_type;

endpackage

FILE: design/segmented_prime_sieve_counter.sv
// ----------------------------------------------------------------------------
// segmented_prime_sieve_counter
// counts primes in a closed range with a segmented sieve, one request at a time
// an empty or oversized range skips to publish; otherwise a fill pass and a count pass over the span,
// plus a remainder step for each odd p with p*p <= high, a remainder step per trial
// divisor and one strike per multiple in the span for each sieving prime (remainder unit bound)
// requests: one at a time, the next is taken in idle once the result is published
// reset: synchronous, clears the sequencer, remainder unit and result valid; no map clear
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segmented_prime_sieve_counter #(
   parameter int SEGMENT_SIZE = 1024,
   parameter int VALUE_WIDTH  = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [VALUE_WIDTH-1:0]           req_low_bound,
   input  logic [VALUE_WIDTH-1:0]           req_high_bound,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [spsc_pkg::COUNT_WIDTH-1:0] rsp_prime_count,
   output logic                             rsp_range_error
);
   import spsc_pkg::*;

   `include "segmented_prime_sieve_counter_defines.svh"

   cmd_type    cmd;
   status_type status;

   spsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   spsc_dp #(
      .SEGMENT_SIZE (SEGMENT_SIZE),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_low_bound   (req_low_bound),
      .req_high_bound  (req_high_bound),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_prime_count (rsp_prime_count),
      .rsp_range_error (rsp_range_error)
   );

   `SPSC_ASSERT(a_err_zero, clock, reset, (rsp_valid && rsp_range_error) |-> (rsp_prime_count == '0), "range error with nonzero count")
   `SPSC_ASSERT(a_busy_after_req, clock, reset, (req_valid && !req_stall) |=> req_stall, "request accepted but block not busy")
   `SPSC_ASSERT_NEVER(a_div_idle, clock, reset, status.div_busy && !req_stall, "remainder unit busy while idle")

endmodule

FILE: design/spsc_div.sv
// ----------------------------------------------------------------------------
// spsc_div
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spsc_div #(
   parameter int DW = 32,
   parameter int SW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [SW-1:0] divisor,
   output logic          busy,
   output logic [SW-1:0] remainder
);
   localparam int CNW = $clog2(DW + 1);

   logic           busy_ff, busy_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]  quo_ff, quo_in;
   logic [SW-1:0]  rem_ff, rem_in;
   logic [SW-1:0]  dsr_ff, dsr_in;
   logic [SW:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[DW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNW'(DW);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial[SW-1:0] - dsr_ff;
         end else begin
            rem_in = trial[SW-1:0];
         end
         quo_in = {quo_ff[DW-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

FILE: design/spsc_dp.sv
// ----------------------------------------------------------------------------
// spsc_dp
// sieve datapath: bounds, candidate bitmap, squarer, remainder unit, tally
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spsc_dp #(
   parameter int SEGMENT_SIZE = 1024,
   parameter int VALUE_WIDTH  = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  spsc_pkg::cmd_type                  cmd,
   output spsc_pkg::status_type               status,
   input  logic [VALUE_WIDTH-1:0]             req_low_bound,
   input  logic [VALUE_WIDTH-1:0]             req_high_bound,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [spsc_pkg::COUNT_WIDTH-1:0]   rsp_prime_count,
   output logic                               rsp_range_error
);
   import spsc_pkg::*;

   localparam int VW = VALUE_WIDTH;
   localparam int AW = $clog2(SEGMENT_SIZE);
   localparam int CW = $clog2(SEGMENT_SIZE + 1);
   localparam int PW = (VW + 1) / 2 + 1;
   localparam int OW = ((PW > CW) ? PW : CW) + 1;
   localparam int WW = ((VW > CW) ? VW : CW) + 1;
   localparam int XW = ((VW > OW) ? VW : OW) + 1;
   localparam int MW = 2 * PW;

   logic                   map_mem [SEGMENT_SIZE];
   logic [VW-1:0]          lo_ff, hi_ff;
   logic                   err_ff;
   logic [CW-1:0]          span_ff, idx_ff;
   logic [PW-1:0]          p_ff, d_ff;
   logic [OW-1:0]          off_ff;
   logic [COUNT_WIDTH-1:0] tally_ff;
   logic                   rd_bit_ff, rd_valid_ff;
   logic                   rsp_valid_ff;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;
   logic                   rsp_err_ff;

   logic [WW-1:0] diff_w, val_w;
   logic          load_err, cand_bit;
   logic [PW-1:0] sq_op, rem;
   logic [MW-1:0] sq_prod, sq_target;
   logic [XW-1:0] hit_w;
   logic          strike_we, map_we, map_wd, div_busy;
   logic [AW-1:0] map_wa;
   logic [VW-1:0] div_dividend;
   logic [PW-1:0] div_divisor;

   assign diff_w   = WW'(req_high_bound) - WW'(req_low_bound);
   assign load_err = (req_high_bound < req_low_bound) || (diff_w >= WW'(SEGMENT_SIZE));

   // value of the bitmap slot being filled
   assign val_w    = WW'(lo_ff) + WW'(idx_ff);
   assign cand_bit = (val_w == WW'(2)) || ((val_w >= WW'(3)) && val_w[0]);

   assign sq_op     = cmd.sel_d ? d_ff : p_ff;
   assign sq_prod   = MW'(sq_op) * MW'(sq_op);
   assign sq_target = cmd.sel_d ? MW'(p_ff) : MW'(hi_ff);

   // the sieving prime itself is never struck
   assign hit_w     = XW'(lo_ff) + XW'(off_ff);
   assign strike_we = cmd.strike && (hit_w != XW'(p_ff));

   assign map_we = cmd.init_step || strike_we;
   assign map_wd = cmd.init_step ? cand_bit : 1'b0;
   assign map_wa = cmd.init_step ? idx_ff[AW-1:0] : off_ff[AW-1:0];

   assign div_dividend = cmd.div_p ? VW'(p_ff) : lo_ff;
   assign div_divisor  = cmd.div_p ? d_ff : p_ff;

   spsc_div #(
      .DW (VW),
      .SW (PW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_lo || cmd.div_p),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .remainder (rem)
   );

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_wa] <= map_wd;
      end
      rd_bit_ff <= map_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lo_ff   <= req_low_bound;
         hi_ff   <= req_high_bound;
         err_ff  <= load_err;
         span_ff <= diff_w[CW-1:0] + CW'(1);
      end
      if (cmd.load || cmd.cnt_start) begin
         idx_ff <= '0;
      end else if (cmd.init_step || cmd.cnt_step) begin
         idx_ff <= idx_ff + CW'(1);
      end
      if (cmd.p_init) begin
         p_ff <= PW'(3);
      end else if (cmd.p_next) begin
         p_ff <= p_ff + PW'(2);
      end
      if (cmd.d_init) begin
         d_ff <= PW'(3);
      end else if (cmd.d_next) begin
         d_ff <= d_ff + PW'(2);
      end
      if (cmd.off_calc) begin
         off_ff <= (rem == '0) ? '0 : OW'(p_ff - rem);
      end else if (cmd.strike) begin
         off_ff <= off_ff + OW'(p_ff);
      end
      if (cmd.publish) begin
         rsp_count_ff <= err_ff ? '0 : tally_ff;
         rsp_err_ff   <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tally_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.cnt_step;
         if (cmd.cnt_start) begin
            tally_ff <= '0;
         end else if (rd_valid_ff && rd_bit_ff) begin
            tally_ff <= tally_ff + COUNT_WIDTH'(1);
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.load_err    = load_err;
      status.init_last   = (idx_ff == span_ff - CW'(1));
      status.sq_ok       = (sq_prod <= sq_target);
      status.div_busy    = div_busy;
      status.rem_zero    = (rem == '0);
      status.off_lt_span = (off_ff < OW'(span_ff));
      status.cnt_more    = (idx_ff != span_ff);
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_count = rsp_count_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule

FILE: design/spsc_ctrl.sv
// ----------------------------------------------------------------------------
// spsc_ctrl
// sequencer for fill, sieving-prime search, strike and count passes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  spsc_pkg::status_type status,
   output spsc_pkg::cmd_type    cmd,
   output logic                 req_stall
);
   import spsc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.load_err ? ST_FINISH : ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init_step = 1'b1;
            if (status.init_last) begin
               cmd.p_init = 1'b1;
               state_in   = ST_P_CHECK;
            end
         end
         ST_P_CHECK: begin
            if (status.sq_ok) begin
               cmd.div_lo = 1'b1;
               state_in   = ST_REM_WAIT;
            end else begin
               cmd.cnt_start = 1'b1;
               state_in      = ST_COUNT;
            end
         end
         ST_REM_WAIT: begin
            if (!status.div_busy) begin
               cmd.off_calc = 1'b1;
               state_in     = ST_OFF_CHECK;
            end
         end
         ST_OFF_CHECK: begin
            if (status.off_lt_span) begin
               cmd.d_init = 1'b1;
               state_in   = ST_D_CHECK;
            end else begin
               state_in = ST_P_NEXT;
            end
         end
         ST_D_CHECK: begin
            cmd.sel_d = 1'b1;
            if (status.sq_ok) begin
               cmd.div_p = 1'b1;
               state_in  = ST_D_WAIT;
            end else begin
               state_in = ST_STRIKE;
            end
         end
         ST_D_WAIT: begin
            if (!status.div_busy) begin
               if (status.rem_zero) begin
                  state_in = ST_P_NEXT;
               end else begin
                  cmd.d_next = 1'b1;
                  state_in   = ST_D_CHECK;
               end
            end
         end
         ST_STRIKE: begin
            if (status.off_lt_span) begin
               cmd.strike = 1'b1;
            end else begin
               state_in = ST_P_NEXT;
            end
         end
         ST_P_NEXT: begin
            cmd.p_next = 1'b1;
            state_in   = ST_P_CHECK;
         end
         ST_COUNT: begin
            if (status.cnt_more) begin
               cmd.cnt_step = 1'b1;
            end else begin
               state_in = ST_COUNT_LAST;
            end
         end
         ST_COUNT_LAST: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented prime sieve counter testbench
// drives bound pairs through the request channel, predicts each prime count
// with a local sieve and checks every result in order under random idling and stalling
// ----------------------------------------------------------------------------

module testbench;

   localparam int SEGMENT     = 1024;
   localparam int BOUND_WIDTH = 32;
   localparam int QUIET_LIMIT = 4000000;

   typedef struct {
      logic [spsc_pkg::COUNT_WIDTH-1:0] prime_count;
      logic                             range_error;
   } sieve_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [BOUND_WIDTH-1:0]           req_low_bound = '0;
   logic [BOUND_WIDTH-1:0]           req_high_bound = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [spsc_pkg::COUNT_WIDTH-1:0] rsp_prime_count;
   logic                             rsp_range_error;

   sieve_result_type expected_counts[$];
   int               failures = 0;
   int               sender_idle_pct = 0;
   int               receiver_stall_pct = 0;
   int               quiet_cycles = 0;

   segmented_prime_sieve_counter #(
      .SEGMENT_SIZE(SEGMENT),
      .VALUE_WIDTH (BOUND_WIDTH)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_low_bound  (req_low_bound),
      .req_high_bound (req_high_bound),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_prime_count(rsp_prime_count),
      .rsp_range_error(rsp_range_error)
   );

   always #6 clock = ~clock;

   // local sieve over the requested range
   function automatic sieve_result_type count_primes(logic [31:0] lo_in, logic [31:0] hi_in);
      longint unsigned  lo, hi, span, p, off, d, tally;
      bit               keep[SEGMENT];
      bit               composite;
      sieve_result_type r;
      lo = lo_in;
      hi = hi_in;
      r.prime_count = '0;
      r.range_error = 1'b1;
      if (hi < lo || (hi - lo) >= SEGMENT) return r;
      span = hi - lo + 1;
      for (longint unsigned i = 0; i < span; i++)
         keep[i] = (lo + i == 2) || (lo + i >= 3 && ((lo + i) & 1) != 0);
      for (p = 3; p <= hi / p; p += 2) begin
         off = (lo % p == 0) ? 0 : p - (lo % p);
         if (off >= span) continue;
         composite = 1'b0;
         for (d = 3; d <= p / d; d += 2)
            if (p % d == 0) composite = 1'b1;
         if (composite) continue;
         for (; off < span; off += p)
            if (lo + off != p) keep[off] = 1'b0;
      end
      tally = 0;
      for (longint unsigned i = 0; i < span; i++)
         if (keep[i]) tally++;
      r.prime_count = tally[spsc_pkg::COUNT_WIDTH-1:0];
      r.range_error = 1'b0;
      return r;
   endfunction

   task automatic send_range(logic [31:0] lo, logic [31:0] hi);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_low_bound  <= lo;
      req_high_bound <= hi;
      do @(posedge clock); while (req_stall);
      expected_counts.push_back(count_primes(lo, hi));
   endtask

   task automatic pause_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      pause_sender();
      while (expected_counts.size() != 0) @(posedge clock);
   endtask

   // result checking
   always @(posedge clock) begin
      sieve_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_counts.size() == 0) begin
            $error("result with no request outstanding: count %0d", rsp_prime_count);
            failures++;
         end else begin
            want = expected_counts.pop_front();
            if (rsp_prime_count !== want.prime_count) begin
               $error("prime_count expected %0d actual %0d", want.prime_count,
                      rsp_prime_count);
               failures++;
            end
            if (rsp_range_error !== want.range_error) begin
               $error("range_error expected %0b actual %0b", want.range_error,
                      rsp_range_error);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("segmented_prime_sieve_counter regression: fail");
         $finish;
      end
   end

   task automatic test_range_errors();
      send_range(32'd10, 32'd9);
      send_range(32'hFFFF_FFFF, 32'h0);
      send_range(32'd0, 32'd1024);
      send_range(32'h0, 32'hFFFF_FFFF);
      send_range(32'hAAAA_AAAA, 32'h5555_5555);
   endtask

   task automatic test_extremes();
      send_range(32'd0, 32'd0);
      send_range(32'd0, 32'd1);
      send_range(32'd2, 32'd2);
      send_range(32'd0, 32'd1023);
      send_range(32'd9, 32'd9);
      send_range(32'd25, 32'd25);
      send_range(32'd3, 32'd3);
      send_range(32'd100, 32'd200);
      send_range(32'd1, 32'd1024);
      send_range(32'h00FF_FFC0, 32'h00FF_FFFF);
      // top of the value range, the slowest request
      send_range(32'hFFFF_FFF0, 32'hFFFF_FFFF);
   endtask

   task automatic test_random_ranges(int count);
      logic [31:0] lo, hi;
      int          pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            lo = $urandom_range(3000);
            hi = lo + $urandom_range((pick < 10) ? 1023 : 200);
         end else if (pick < 85) begin
            lo = $urandom;
            hi = $urandom;
            if (hi >= lo && hi - lo < SEGMENT) hi = lo - 1;
         end else begin
            lo = $urandom_range(2000);
            hi = lo + SEGMENT + $urandom_range(50);
         end
         send_range(lo, hi);
      end
   endtask

   task automatic test_drain_pause();
      send_range(32'd500, 32'd700);
      wait_drained();
      send_range(32'd50, 32'd60);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_range_errors();
      test_extremes();
      test_drain_pause();
      test_random_ranges(25);
      sender_idle_pct = 61;
      test_random_ranges(25);
      sender_idle_pct = 0;
      receiver_stall_pct = 61;
      test_random_ranges(25);
      sender_idle_pct = 16;
      receiver_stall_pct = 16;
      test_random_ranges(25);
      wait_drained();
      repeat (50) @(posedge clock);
      if (failures == 0)
         $display("segmented_prime_sieve_counter regression: pass");
      else
         $display("segmented_prime_sieve_counter regression: fail");
      $finish;
   end

endmodule
